// ===== src/icd_pkg.sv =====
// shared types and constants of the input change event detector
// no dependencies; imported by every module of the block
package icd_pkg;

	localparam int INPUT_BITS = 8;
	localparam int PORT_BITS = 8;
	localparam int SCAN_BITS = (INPUT_BITS < PORT_BITS) ? INPUT_BITS : PORT_BITS;
	localparam int CNT_W = (SCAN_BITS > 1) ? $clog2(SCAN_BITS) : 1;
	localparam int PORT_IDX_W = $clog2(PORT_BITS);
	localparam int EV_IDX_W = 3;
	localparam int TIME_W = 32;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam logic [15:0] HOLDOFF_RESET = 16'd200;

	// register indexes on the config port (byte address / 4)
	typedef enum logic [2:0] {
		REG_RELAY_COUNT = 3'd0,
		REG_CUSTOM_MAPPING = 3'd1,
		REG_DIRECTION_MASK = 3'd2,
		REG_EVENTS_ENABLE = 3'd3,
		REG_HOLDOFF_MS = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic [3:0] relay_count;
		logic custom_mapping;
		logic [PORT_BITS-1:0] direction_mask;
		logic events_enable;
		logic [15:0] holdoff_ms;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic emit_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic check_en;
		logic scan_last;
		logic out_free;
		logic emit_last;
	} sts_t;

endpackage

// ===== src/icd_ctrl.sv =====
// sequencing state machine of the input change event detector
// depends on icd_pkg; drives commands into icd_datapath
module icd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  icd_pkg::sts_t sts,
	output icd_pkg::cmd_t cmd
);
	import icd_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.check_en ? ST_SCAN : ST_EMIT;
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free && sts.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN: cmd.scan = 1'b1;
			ST_EMIT: cmd.emit_load = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ===== src/icd_datapath.sv =====
// status shaping, per-bit holdoff check and result register
// depends on icd_pkg; commanded by icd_ctrl
module icd_datapath (
	input  logic clk,
	input  logic arst_n,
	input  icd_pkg::cfg_t cfg,
	input  logic [icd_pkg::PORT_BITS-1:0] port_sample,
	input  logic [icd_pkg::TIME_W-1:0] now_ms,
	input  logic out_ready,
	input  icd_pkg::cmd_t cmd,
	output icd_pkg::sts_t sts,
	output logic out_valid,
	output logic [icd_pkg::PORT_BITS-1:0] input_status,
	output logic event_valid,
	output logic [icd_pkg::EV_IDX_W-1:0] event_index,
	output logic event_level,
	output logic last_result
);
	import icd_pkg::*;

	logic [PORT_BITS-1:0] prev_q, status_q, status_new, inverted;
	logic first_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] change_times_q [SCAN_BITS];
	logic [SCAN_BITS-1:0] qual_q, qual_rest;
	logic [CNT_W-1:0] cnt_q, low_idx;
	logic [3:0] offset;
	logic [4:0] dpos;
	logic is_input, held, bit_hit;
	logic [TIME_W-1:0] elapsed;
	logic out_valid_q;

	// shaped status of the incoming sample
	assign offset = cfg.custom_mapping ? 4'd0 : cfg.relay_count;
	assign inverted = ~port_sample;
	assign status_new = (offset >= 4'(PORT_BITS)) ? '0 : (inverted >> offset);

	// per-bit check of the scanned bit
	assign dpos = 5'(cnt_q) + 5'(offset);
	assign is_input = (dpos < 5'(PORT_BITS)) && cfg.direction_mask[dpos[PORT_IDX_W-1:0]];
	assign elapsed = now_q - change_times_q[cnt_q];
	assign held = !elapsed[TIME_W-1] && (elapsed > TIME_W'(cfg.holdoff_ms));
	assign bit_hit = is_input && (status_q[cnt_q] ^ prev_q[cnt_q]) && held;

	// lowest qualifying bit is reported first
	always_comb begin
		low_idx = '0;
		for (int i = SCAN_BITS - 1; i >= 0; i--) begin
			if (qual_q[i]) begin
				low_idx = CNT_W'(i);
			end
		end
	end
	assign qual_rest = qual_q & (qual_q - 1'b1);

	assign sts.check_en = cfg.events_enable && !first_q && (status_new != prev_q);
	assign sts.scan_last = (cnt_q == CNT_W'(SCAN_BITS - 1));
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.emit_last = (qual_rest == '0);

	// prev_q holds the previous sample's status until the last result beat is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			prev_q <= '0;
			first_q <= 1'b1;
			qual_q <= '0;
			cnt_q <= '0;
			for (int i = 0; i < SCAN_BITS; i++) begin
				change_times_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				status_q <= status_new;
				prev_q <= status_q;
				first_q <= 1'b0;
				qual_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.scan) begin
				cnt_q <= cnt_q + 1'b1;
				if (bit_hit) begin
					qual_q[cnt_q] <= 1'b1;
					change_times_q[cnt_q] <= now_q;
				end
			end
			if (cmd.emit_load) begin
				qual_q <= qual_rest;
				if (sts.emit_last) begin
					prev_q <= status_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= now_ms;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			input_status <= status_q;
			event_valid <= (qual_q != '0);
			event_index <= (qual_q != '0) ? EV_IDX_W'(low_idx) : '0;
			event_level <= (qual_q != '0) ? status_q[low_idx] : 1'b0;
			last_result <= sts.emit_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/input_change_event_detector_core.sv =====
// input change event detector, top level with config registers
// depends on icd_pkg, icd_ctrl and icd_datapath
// sequence: the sample is taken in idle, then all 8 bits are scanned when events are checked,
//   then one beat per reported event (a plain beat when nothing qualifies)
// sample flow: a new sample is taken only after the last result beat of the previous one;
//   the single shared holdoff compare checks one bit per cycle during the scan
// reset: config to defaults (holdoff 200 ms), status and change times to zero
module input_change_event_detector_core (
	input  logic clk,
	input  logic arst_n,
	// sample channel
	input  logic in_valid,
	output logic in_ready,
	input  logic [icd_pkg::PORT_BITS-1:0] port_sample,
	input  logic [icd_pkg::TIME_W-1:0] now_ms,
	// result channel
	output logic out_valid,
	input  logic out_ready,
	output logic [icd_pkg::PORT_BITS-1:0] input_status,
	output logic event_valid,
	output logic [icd_pkg::EV_IDX_W-1:0] event_index,
	output logic event_level,
	output logic last_result,
	// config port
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [icd_pkg::ADDR_W-1:0] paddr,
	input  logic [icd_pkg::DATA_W-1:0] pwdata,
	output logic [icd_pkg::DATA_W-1:0] prdata,
	output logic pready
);
	import icd_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic wr_en;
	reg_idx_t reg_idx;

	// config registers, word addressed; unknown indexes are dropped
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.relay_count <= '0;
			cfg_q.custom_mapping <= 1'b0;
			cfg_q.direction_mask <= '0;
			cfg_q.events_enable <= 1'b0;
			cfg_q.holdoff_ms <= HOLDOFF_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RELAY_COUNT: cfg_q.relay_count <= pwdata[3:0];
				REG_CUSTOM_MAPPING: cfg_q.custom_mapping <= pwdata[0];
				REG_DIRECTION_MASK: cfg_q.direction_mask <= pwdata[PORT_BITS-1:0];
				REG_EVENTS_ENABLE: cfg_q.events_enable <= pwdata[0];
				REG_HOLDOFF_MS: cfg_q.holdoff_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_RELAY_COUNT: prdata = DATA_W'(cfg_q.relay_count);
			REG_CUSTOM_MAPPING: prdata = DATA_W'(cfg_q.custom_mapping);
			REG_DIRECTION_MASK: prdata = DATA_W'(cfg_q.direction_mask);
			REG_EVENTS_ENABLE: prdata = DATA_W'(cfg_q.events_enable);
			REG_HOLDOFF_MS: prdata = DATA_W'(cfg_q.holdoff_ms);
			default: prdata = '0;
		endcase
	end

	// sequencer: idle -> scan (8 bits, only when events are checked) -> emit beats -> idle
	icd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts(sts),
		.cmd(cmd)
	);

	// status shaping, holdoff check, change times and result register
	icd_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.port_sample(port_sample),
		.now_ms(now_ms),
		.out_ready(out_ready),
		.cmd(cmd),
		.sts(sts),
		.out_valid(out_valid),
		.input_status(input_status),
		.event_valid(event_valid),
		.event_index(event_index),
		.event_level(event_level),
		.last_result(last_result)
	);

	// a reported level is the status bit at the reported index
	a_level_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_valid |-> input_status[event_index] == event_level)
		else $error("event level differs from status bit");

	// a plain beat always closes its sample
	a_plain_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !event_valid |-> last_result)
		else $error("plain beat not marked last");

	// one sample at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample taken while busy");

endmodule
